// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL files; line_edge_search includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/les_pkg.sv
// Shared constants and types for the scan line edge search block.
package les_pkg;

  localparam int PIXEL_BITS_DEF = 8;
  localparam int POS_W          = 12;
  localparam int LLEN_W         = 13;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 13;
  localparam int STR_W          = 8;

  // Highest line number a shield bound may take before the band is ignored.
  localparam logic [16:0] MAX_LINE = 17'd4096;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GRAD      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_TO_LIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ONLY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LEN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHIELD_A      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SHIELD_B      = 3'd7;

  // Register values after reset.
  localparam logic [7:0]        RST_MIN_GRAD      = 8'd10;
  localparam logic [7:0]        RST_EDGE_LEVEL    = 8'd128;
  localparam logic              RST_DARK_TO_LIGHT = 1'b1;
  localparam logic              RST_FIRST_ONLY    = 1'b0;
  localparam logic [POS_W-1:0]  RST_WINDOW_LEN    = 12'd8;
  localparam logic [LLEN_W-1:0] RST_LINE_LEN      = 13'd640;
  localparam logic [POS_W-1:0]  RST_SHIELD_A      = 12'd0;
  localparam logic [POS_W-1:0]  RST_SHIELD_B      = 12'd0;

  typedef enum logic [1:0] {
    ST_FOUND  = 2'd0,
    ST_NONE   = 2'd1,
    ST_SHIELD = 2'd2,
    ST_WINDOW = 2'd3
  } les_status_t;

endpackage

// File: rtl/core/line_edge_search.sv
// Edge search along one scan line: candidate test, best tracking and window placement.
//
// Usage: pixels of a scan line enter on the in_ channel in scan order, one word per
// pixel, with their coordinate and line number; in_line_end marks the last pixel.
// Every pixel pair is tested as an edge candidate, and the first or strongest one
// is kept. For each line-ending word one result word leaves on the out_ channel
// with status, edge position, strength, clamped window start and line number.
// Both channels use valid/ready; the cfg_ port writes a register on each cfg_we and
// must only be used while no line is in flight.
// Throughput: one pixel per cycle while no line-ending pixel waits, set by a single
// compare-and-update of the line state. A line-ending pixel's result passes from the
// input register to the line register and then to the output register.
// When the receiver stalls, the output register holds its word and the line
// register behind it still takes one more result; pixels that end no line keep
// flowing, while a line-ending pixel waits in the input register until the line
// register frees up. Reset (synchronous, active low) restores the register
// defaults and empties the pipeline and the line state.
`include "assert_macros.svh"

module line_edge_search
  import les_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  input  logic [POS_W-1:0]      in_pixel_pos,
  input  logic [POS_W-1:0]      in_line_index,
  input  logic                  in_line_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [POS_W-1:0]      out_edge_pos,
  output logic [STR_W-1:0]      out_edge_strength,
  output logic [POS_W-1:0]      out_window_start,
  output logic [POS_W-1:0]      out_line_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PB = PIXEL_BITS;

  // Configuration registers.
  logic [7:0]        min_grad_r;
  logic [7:0]        edge_level_r;
  logic              dark_to_light_r;
  logic              first_only_r;
  logic [POS_W-1:0]  window_len_r;
  logic [LLEN_W-1:0] line_len_r;
  logic [POS_W-1:0]  shield_a_r;
  logic [POS_W-1:0]  shield_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_grad_r      <= RST_MIN_GRAD;
      edge_level_r    <= RST_EDGE_LEVEL;
      dark_to_light_r <= RST_DARK_TO_LIGHT;
      first_only_r    <= RST_FIRST_ONLY;
      window_len_r    <= RST_WINDOW_LEN;
      line_len_r      <= RST_LINE_LEN;
      shield_a_r      <= RST_SHIELD_A;
      shield_b_r      <= RST_SHIELD_B;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_GRAD:      min_grad_r      <= cfg_data[7:0];
        REG_EDGE_LEVEL:    edge_level_r    <= cfg_data[7:0];
        REG_DARK_TO_LIGHT: dark_to_light_r <= cfg_data[0];
        REG_FIRST_ONLY:    first_only_r    <= cfg_data[0];
        REG_WINDOW_LEN:    window_len_r    <= cfg_data[POS_W-1:0];
        REG_LINE_LEN:      line_len_r      <= cfg_data[LLEN_W-1:0];
        REG_SHIELD_A:      shield_a_r      <= cfg_data[POS_W-1:0];
        REG_SHIELD_B:      shield_b_r      <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  logic out_v_r, out_v_nxt;
  logic s1_go, s2_ready, s2_go, in_acc;

  logic [PB-1:0]    s1_pixel_r;
  logic [POS_W-1:0] s1_pos_r;
  logic [POS_W-1:0] s1_line_r;
  logic             s1_last_r;

  assign s2_ready = !s2_v_r || !out_v_r || out_ready;
  assign s2_go    = s2_v_r && (!out_v_r || out_ready);
  // A pixel that ends no line never waits on the stages behind it.
  assign s1_go    = s1_v_r && (!s1_last_r || s2_ready);
  assign in_ready = !s1_v_r || s1_go;
  assign in_acc   = in_valid && in_ready;

  assign s1_v_nxt  = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
  assign s2_v_nxt  = (s1_go && s1_last_r) ? 1'b1 : (s2_go ? 1'b0 : s2_v_r);
  assign out_v_nxt = (!out_v_r || out_ready) ? s2_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel_r <= in_pixel;
      s1_pos_r   <= in_pixel_pos;
      s1_line_r  <= in_line_index;
      s1_last_r  <= in_line_end;
    end
  end

  // Line state.
  logic [PB-1:0]    prev_pixel_r, prev_pixel_nxt;
  logic [POS_W-1:0] prev_pos_r, prev_pos_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic [PB-1:0]    best_str_r, best_str_nxt;
  logic [POS_W-1:0] best_pos_r, best_pos_nxt;
  logic             any_found_r, any_found_nxt;
  logic             stopped_r, stopped_nxt;

  // Candidate test on the pair (previous pixel, pixel in the input register).
  logic [PB-1:0]    p1, p2, lvl, mg, diff_up, diff_dn, strength;
  logic             cand_up, cand_dn, cand, take;
  logic [PB-1:0]    upd_str;
  logic [POS_W-1:0] upd_pos;
  logic             upd_any, upd_stop;

  always_comb begin
    p1       = prev_pixel_r;
    p2       = s1_pixel_r;
    lvl      = PB'(edge_level_r);
    mg       = PB'(min_grad_r);
    diff_up  = p2 - p1;
    diff_dn  = p1 - p2;
    cand_up  = (p2 > p1) && (diff_up > mg) && (p1 <= lvl) && (p2 >= lvl);
    cand_dn  = (p1 > p2) && (diff_dn > mg) && (p1 >= lvl) && (p2 <= lvl);
    strength = dark_to_light_r ? diff_up : diff_dn;
    cand     = have_prev_r && !stopped_r && (dark_to_light_r ? cand_up : cand_dn);
    // Ties keep the earlier candidate, so only a strictly stronger one replaces it.
    take     = cand && (!any_found_r || (strength > best_str_r));
    upd_str  = take ? strength : best_str_r;
    upd_pos  = take ? prev_pos_r : best_pos_r;
    upd_any  = any_found_r || cand;
    upd_stop = stopped_r || (cand && first_only_r);
  end

  always_comb begin
    prev_pixel_nxt = prev_pixel_r;
    prev_pos_nxt   = prev_pos_r;
    have_prev_nxt  = have_prev_r;
    best_str_nxt   = best_str_r;
    best_pos_nxt   = best_pos_r;
    any_found_nxt  = any_found_r;
    stopped_nxt    = stopped_r;
    if (s1_go) begin
      if (s1_last_r) begin
        prev_pixel_nxt = '0;
        prev_pos_nxt   = '0;
        have_prev_nxt  = 1'b0;
        best_str_nxt   = '0;
        best_pos_nxt   = '0;
        any_found_nxt  = 1'b0;
        stopped_nxt    = 1'b0;
      end else begin
        prev_pixel_nxt = s1_pixel_r;
        prev_pos_nxt   = s1_pos_r;
        have_prev_nxt  = 1'b1;
        best_str_nxt   = upd_str;
        best_pos_nxt   = upd_pos;
        any_found_nxt  = upd_any;
        stopped_nxt    = upd_stop;
      end
    end
  end

  // Finished line, waiting for status and window placement.
  logic             s2_any_r;
  logic [PB-1:0]    s2_str_r;
  logic [POS_W-1:0] s2_pos_r;
  logic [POS_W-1:0] s2_line_r;

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      s2_any_r  <= upd_any;
      s2_str_r  <= upd_str;
      s2_pos_r  <= upd_pos;
      s2_line_r <= s1_line_r;
    end
  end

  // Shield band and window placement.
  logic [POS_W-1:0]  sh_lo, sh_hi, half;
  logic              shielded;
  logic signed [15:0] lim, p_s, s_s, tail_s;
  logic [POS_W-1:0]  win_start;
  logic [STR_W-1:0]  str_sat;
  les_status_t       status;
  logic [POS_W-1:0]  res_pos, res_win;
  logic [STR_W-1:0]  res_str;

  always_comb begin
    sh_lo    = (shield_a_r < shield_b_r) ? shield_a_r : shield_b_r;
    sh_hi    = (shield_a_r < shield_b_r) ? shield_b_r : shield_a_r;
    shielded = (sh_lo != sh_hi) && ({5'b0, sh_lo} <= MAX_LINE) && ({5'b0, sh_hi} <= MAX_LINE)
               && (s2_line_r > sh_lo) && (s2_line_r < sh_hi);

    half   = window_len_r >> 1;
    p_s    = $signed({4'b0, s2_pos_r});
    lim    = $signed({3'b0, line_len_r}) - $signed({4'b0, half}) - 16'sd1;
    tail_s = $signed({3'b0, line_len_r}) - $signed({4'b0, window_len_r});
    if (s2_pos_r < half) begin
      s_s = 16'sd0;
    end else if (p_s > lim) begin
      s_s = tail_s;
    end else begin
      s_s = p_s - $signed({4'b0, half});
    end
    if (s_s < 16'sd0) begin
      win_start = '0;
    end else if (s_s > 16'sd4095) begin
      win_start = '1;
    end else begin
      win_start = s_s[POS_W-1:0];
    end

    str_sat = (s2_str_r > PB'(8'hFF)) ? 8'hFF : s2_str_r[STR_W-1:0];

    res_pos = '0;
    res_str = '0;
    res_win = '0;
    if ({1'b0, window_len_r} >= line_len_r) begin
      status = ST_WINDOW;
    end else if (shielded) begin
      status = ST_SHIELD;
    end else if (s2_any_r) begin
      status  = ST_FOUND;
      res_pos = s2_pos_r;
      res_str = str_sat;
      res_win = win_start;
    end else begin
      status = ST_NONE;
    end
  end

  les_status_t      out_status_r;
  logic [POS_W-1:0] out_pos_r, out_win_r, out_line_r;
  logic [STR_W-1:0] out_str_r;

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_status_r <= status;
      out_pos_r    <= res_pos;
      out_str_r    <= res_str;
      out_win_r    <= res_win;
      out_line_r   <= s2_line_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      prev_pixel_r <= '0;
      prev_pos_r   <= '0;
      have_prev_r  <= 1'b0;
      best_str_r   <= '0;
      best_pos_r   <= '0;
      any_found_r  <= 1'b0;
      stopped_r    <= 1'b0;
    end else begin
      s1_v_r       <= s1_v_nxt;
      s2_v_r       <= s2_v_nxt;
      out_v_r      <= out_v_nxt;
      prev_pixel_r <= prev_pixel_nxt;
      prev_pos_r   <= prev_pos_nxt;
      have_prev_r  <= have_prev_nxt;
      best_str_r   <= best_str_nxt;
      best_pos_r   <= best_pos_nxt;
      any_found_r  <= any_found_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_status        = out_status_r;
  assign out_edge_pos      = out_pos_r;
  assign out_edge_strength = out_str_r;
  assign out_window_start  = out_win_r;
  assign out_line_out      = out_line_r;

  // A stopped search always has a kept candidate behind it.
  `ASSERT_SAME(a_stop_has_edge, clk, rst_n, stopped_r, any_found_r)
  // The input side only stalls while a word sits in the input register.
  `ASSERT_SAME(a_stall_needs_item, clk, rst_n, !in_ready, s1_v_r)
  // A line-ending word that leaves the input register lands in the line register.
  `ASSERT_NEXT(a_line_to_s2, clk, rst_n, s1_go && s1_last_r, s2_v_r)
  // Only a found edge carries position, strength and window.
  `ASSERT_SAME(a_empty_fields, clk, rst_n, out_v_r && (out_status_r != ST_FOUND),
               (out_pos_r == '0) && (out_str_r == '0) && (out_win_r == '0))

endmodule

// File: tb/line_edge_checker.sv
// Checker for the scan line edge search: tracks each line, predicts results and compares them.
module line_edge_checker
  import les_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [PIXEL_BITS_DEF-1:0] in_pixel,
  input  logic [POS_W-1:0]          in_pixel_pos,
  input  logic [POS_W-1:0]          in_line_index,
  input  logic                      in_line_end,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [1:0]                out_status,
  input  logic [POS_W-1:0]          out_edge_pos,
  input  logic [STR_W-1:0]          out_edge_strength,
  input  logic [POS_W-1:0]          out_window_start,
  input  logic [POS_W-1:0]          out_line_out,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    les_status_t      status;
    logic [POS_W-1:0] edge_pos;
    logic [STR_W-1:0] strength;
    logic [POS_W-1:0] window_start;
    logic [POS_W-1:0] line_no;
  } line_result_t;

  line_result_t expected_lines[$];

  // Register copies.
  logic [7:0]        min_grad;
  logic [7:0]        edge_level;
  logic              rising;
  logic              first_only;
  logic [POS_W-1:0]  window_len;
  logic [LLEN_W-1:0] line_len;
  logic [POS_W-1:0]  shield_a;
  logic [POS_W-1:0]  shield_b;

  // Per-line search state.
  logic [7:0]        prev_pixel;
  logic [POS_W-1:0]  prev_pos;
  logic              have_prev;
  logic [STR_W-1:0]  best_strength;
  logic [POS_W-1:0]  best_pos;
  logic              any_found;
  logic              search_stopped;

  function automatic logic [POS_W-1:0] window_start_for(input logic [POS_W-1:0] pos);
    int half;
    int s;
    half = int'(window_len) / 2;
    if (int'(pos) < half) s = 0;
    else if (int'(pos) > int'(line_len) - half - 1) s = int'(line_len) - int'(window_len);
    else s = int'(pos) - half;
    if (s < 0) s = 0;
    if (s > 4095) s = 4095;
    return s[POS_W-1:0];
  endfunction

  // The band excludes lines strictly between the two bounds.
  function automatic logic line_in_band(input logic [POS_W-1:0] line_no);
    int lo;
    int hi;
    lo = (shield_a < shield_b) ? int'(shield_a) : int'(shield_b);
    hi = (shield_a < shield_b) ? int'(shield_b) : int'(shield_a);
    if (lo == hi || lo > int'(MAX_LINE) || hi > int'(MAX_LINE)) return 1'b0;
    return (int'(line_no) > lo) && (int'(line_no) < hi);
  endfunction

  task automatic clear_line_state();
    prev_pixel     = '0;
    prev_pos       = '0;
    have_prev      = 1'b0;
    best_strength  = '0;
    best_pos       = '0;
    any_found      = 1'b0;
    search_stopped = 1'b0;
  endtask

  task automatic take_pixel(input logic [7:0] pix, input logic [POS_W-1:0] pos,
                            input logic [POS_W-1:0] line_no, input logic last);
    logic         cand;
    logic [7:0]   grad;
    line_result_t res;
    cand = 1'b0;
    grad = '0;
    if (have_prev && !search_stopped) begin
      if (rising) begin
        if (pix > prev_pixel && pix - prev_pixel > min_grad &&
            prev_pixel <= edge_level && pix >= edge_level) begin
          cand = 1'b1;
          grad = pix - prev_pixel;
        end
      end else begin
        if (prev_pixel > pix && prev_pixel - pix > min_grad &&
            prev_pixel >= edge_level && pix <= edge_level) begin
          cand = 1'b1;
          grad = prev_pixel - pix;
        end
      end
      // Strict compare keeps the earlier pair on equal strength.
      if (cand && (!any_found || grad > best_strength)) begin
        best_strength = grad;
        best_pos      = prev_pos;
        any_found     = 1'b1;
      end
      if (cand && first_only) search_stopped = 1'b1;
    end
    prev_pixel = pix;
    prev_pos   = pos;
    have_prev  = 1'b1;
    if (last) begin
      res = '0;
      res.line_no = line_no;
      if (window_len >= line_len) begin
        res.status = ST_WINDOW;
      end else if (line_in_band(line_no)) begin
        res.status = ST_SHIELD;
      end else if (any_found) begin
        res.status       = ST_FOUND;
        res.edge_pos     = best_pos;
        res.strength     = best_strength;
        res.window_start = window_start_for(best_pos);
      end else begin
        res.status = ST_NONE;
      end
      expected_lines = {expected_lines, res};
      clear_line_state();
    end
  endtask

  always @(posedge clk) begin
    line_result_t exp_word;
    if (!rst_n) begin
      min_grad   = RST_MIN_GRAD;
      edge_level = RST_EDGE_LEVEL;
      rising     = RST_DARK_TO_LIGHT;
      first_only = RST_FIRST_ONLY;
      window_len = RST_WINDOW_LEN;
      line_len   = RST_LINE_LEN;
      shield_a   = RST_SHIELD_A;
      shield_b   = RST_SHIELD_B;
      clear_line_state();
      expected_lines.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_GRAD:      min_grad   = cfg_data[7:0];
          REG_EDGE_LEVEL:    edge_level = cfg_data[7:0];
          REG_DARK_TO_LIGHT: rising     = cfg_data[0];
          REG_FIRST_ONLY:    first_only = cfg_data[0];
          REG_WINDOW_LEN:    window_len = cfg_data[POS_W-1:0];
          REG_LINE_LEN:      line_len   = cfg_data[LLEN_W-1:0];
          REG_SHIELD_A:      shield_a   = cfg_data[POS_W-1:0];
          REG_SHIELD_B:      shield_b   = cfg_data[POS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        take_pixel(in_pixel, in_pixel_pos, in_line_index, in_line_end);
      if (out_valid && out_ready) begin
        if (expected_lines.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result word: status=%0d pos=%0d strength=%0d win=%0d line=%0d",
                     out_status, out_edge_pos, out_edge_strength, out_window_start,
                     out_line_out);
          fail_count++;
        end else begin
          exp_word = expected_lines.pop_front();
          if (exp_word.status != les_status_t'(out_status) ||
              exp_word.edge_pos != out_edge_pos ||
              exp_word.strength != out_edge_strength ||
              exp_word.window_start != out_window_start ||
              exp_word.line_no != out_line_out) begin
            if (fail_count < 10) begin
              $display("mismatch: expected status=%0d pos=%0d strength=%0d win=%0d line=%0d",
                       exp_word.status, exp_word.edge_pos, exp_word.strength,
                       exp_word.window_start, exp_word.line_no);
              $display("          actual   status=%0d pos=%0d strength=%0d win=%0d line=%0d",
                       out_status, out_edge_pos, out_edge_strength, out_window_start,
                       out_line_out);
            end
            fail_count++;
          end
        end
      end
    end
    pending = expected_lines.size();
  end

endmodule

// File: tb/line_edge_search_test.sv
// Top of the edge search testbench: clock, reset, pixel and register stimulus, verdict.
module line_edge_search_test
  import les_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 1200;
  localparam int PHASE_WORDS    = 150;

  logic                      clk;
  logic                      rst_n         = 1'b0;
  logic                      in_valid      = 1'b0;
  logic                      in_ready;
  logic [PIXEL_BITS_DEF-1:0] in_pixel      = '0;
  logic [POS_W-1:0]          in_pixel_pos  = '0;
  logic [POS_W-1:0]          in_line_index = '0;
  logic                      in_line_end   = 1'b0;
  logic                      out_valid;
  logic                      out_ready     = 1'b0;
  logic [1:0]                out_status;
  logic [POS_W-1:0]          out_edge_pos;
  logic [STR_W-1:0]          out_edge_strength;
  logic [POS_W-1:0]          out_window_start;
  logic [POS_W-1:0]          out_line_out;
  logic                      cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index     = REG_MIN_GRAD;
  logic [CFG_DATA_W-1:0]     cfg_data      = '0;

  int         fail_count;
  int         pending;
  bit         idle_on     = 1'b1;
  int         stall_left  = 0;
  int         idle_cycles = 0;
  int         words_sent  = 0;
  logic [7:0] cur_level   = RST_EDGE_LEVEL;

  line_edge_search dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel          (in_pixel),
    .in_pixel_pos      (in_pixel_pos),
    .in_line_index     (in_line_index),
    .in_line_end       (in_line_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_edge_pos      (out_edge_pos),
    .out_edge_strength (out_edge_strength),
    .out_window_start  (out_window_start),
    .out_line_out      (out_line_out),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  line_edge_checker scoreboard (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel          (in_pixel),
    .in_pixel_pos      (in_pixel_pos),
    .in_line_index     (in_line_index),
    .in_line_end       (in_line_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_edge_pos      (out_edge_pos),
    .out_edge_strength (out_edge_strength),
    .out_window_start  (out_window_start),
    .out_line_out      (out_line_out),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result side: out_ready drops in random stall bursts, only while idle_on is set.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = int'($urandom_range(0, 4));
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [7:0] pix, input logic [POS_W-1:0] pos,
                           input logic [POS_W-1:0] line_no, input logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_pixel      <= pix;
    in_pixel_pos  <= pos;
    in_line_index <= line_no;
    in_line_end   <= last;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  // Holds the sender until every predicted result has left the block.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic write_config(input logic [CFG_DATA_W-1:0] mg, el, dl, fo, wl, ll, sa, sb);
    write_reg(REG_MIN_GRAD, mg);
    write_reg(REG_EDGE_LEVEL, el);
    write_reg(REG_DARK_TO_LIGHT, dl);
    write_reg(REG_FIRST_ONLY, fo);
    write_reg(REG_WINDOW_LEN, wl);
    write_reg(REG_LINE_LEN, ll);
    write_reg(REG_SHIELD_A, sa);
    write_reg(REG_SHIELD_B, sb);
    cfg_we <= 1'b0;
    cur_level = el[7:0];
  endtask

  task automatic random_config(input logic [POS_W-1:0] base);
    logic [CFG_DATA_W-1:0] mg, el, wl, ll;
    logic [POS_W-1:0]      sa, sb;
    case ($urandom_range(0, 9))
      0: mg = 13'd0;
      1: mg = 13'd255;
      2: mg = 13'(($urandom_range(1, 31) << 8) | $urandom_range(0, 255));
      default: mg = 13'($urandom_range(0, 60));
    endcase
    case ($urandom_range(0, 9))
      0: el = 13'd0;
      1: el = 13'd255;
      2: el = 13'(($urandom_range(1, 31) << 8) | $urandom_range(0, 255));
      default: el = 13'($urandom_range(40, 215));
    endcase
    case ($urandom_range(0, 9))
      0: wl = 13'd0;
      1: wl = 13'd1;
      2: wl = 13'd4095;
      default: wl = 13'($urandom_range(2, 64));
    endcase
    case ($urandom_range(0, 9))
      0: ll = 13'($urandom_range(0, 1));
      1: ll = 13'd4096;
      2: ll = 13'($urandom_range(4097, 8191));
      3: ll = wl;
      default: ll = 13'($urandom_range(16, 4096));
    endcase
    // Half of the bands sit around the lines of this phase so that some lines fall inside.
    case ($urandom_range(0, 3))
      0: begin
        sa = 12'($urandom_range(0, 4095));
        sb = sa;
      end
      1: begin
        sa = 12'($urandom_range(0, 4095));
        sb = 12'($urandom_range(0, 4095));
      end
      default: begin
        sa = base + 12'($urandom_range(0, 8));
        sb = base + 12'($urandom_range(2, 30));
      end
    endcase
    write_config(mg, el, 13'($urandom_range(0, 1)), 13'($urandom_range(0, 1)), wl, ll,
                 {1'b0, sa}, {1'b0, sb});
  endtask

  // One scan line; a scrambled line changes line number and position on every word.
  task automatic send_line(input int n, input logic [POS_W-1:0] line_no, input bit scrambled);
    int               kind;
    int               lo;
    int               hi;
    int               a;
    int               b;
    int               k;
    int               v;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] step;
    kind = int'($urandom_range(0, 3));
    lo   = int'($urandom_range(0, cur_level));
    hi   = int'($urandom_range(cur_level, 255));
    if ($urandom_range(0, 1) == 1) begin
      a = lo;
      b = hi;
    end else begin
      a = hi;
      b = lo;
    end
    k    = (n > 1) ? int'($urandom_range(1, n - 1)) : 0;
    pos  = ($urandom_range(0, 1) == 1) ? 12'($urandom_range(0, 40)) : 12'($urandom_range(0, 4095));
    step = ($urandom_range(0, 1) == 1) ? 12'd1 : 12'hFFF;
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: v = int'($urandom_range(0, 255));
        1: v = (i < k) ? a : b;
        2: v = (i % 2 == 0) ? a : b;
        default: begin
          case ($urandom_range(0, 3))
            0: v = lo;
            1: v = hi;
            2: v = int'(cur_level);
            default: v = int'($urandom_range(0, 255));
          endcase
        end
      endcase
      if (kind == 1 && $urandom_range(0, 3) == 0) v = v + int'($urandom_range(0, 8)) - 4;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      if (scrambled)
        send_word(8'(v), 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), i == n - 1);
      else
        send_word(8'(v), pos, line_no, i == n - 1);
      pos = pos + step;
    end
  endtask

  initial begin
    int               rand_start;
    int               phase_start;
    int               phase;
    int               n;
    logic [POS_W-1:0] line_no;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Register defaults: single-pixel line, extreme pixels and positions, clamps, ties.
    send_word(8'd77, 12'd5, 12'd0, 1'b1);
    send_word(8'd0, 12'd0, 12'd4095, 1'b0);
    send_word(8'd255, 12'd1, 12'd4095, 1'b1);
    send_word(8'd0, 12'd4095, 12'd12, 1'b0);
    send_word(8'd255, 12'd4094, 12'd12, 1'b1);
    send_word(8'd120, 12'd10, 12'd7, 1'b0);
    send_word(8'd140, 12'd11, 12'd7, 1'b0);
    send_word(8'd120, 12'd12, 12'd7, 1'b0);
    send_word(8'd140, 12'd13, 12'd7, 1'b1);
    wait_drained();

    // Falling edges, first candidate only, shield band between lines 3 and 9.
    write_config(13'd100, 13'd100, 13'd0, 13'd1, 13'd4095, 13'd4096, 13'd9, 13'd3);
    send_word(8'd255, 12'd50, 12'd5, 1'b0);
    send_word(8'd0, 12'd51, 12'd5, 1'b1);
    send_word(8'd200, 12'd3000, 12'd3, 1'b0);
    send_word(8'd50, 12'd3001, 12'd3, 1'b0);
    send_word(8'd255, 12'd3002, 12'd3, 1'b0);
    send_word(8'd0, 12'd3003, 12'd3, 1'b1);
    wait_drained();

    // Window as long as the line wins over a shielded line.
    write_config(13'd10, 13'd128, 13'd1, 13'd0, 13'd640, 13'd640, 13'd0, 13'd4095);
    send_word(8'd0, 12'd100, 12'd2000, 1'b0);
    send_word(8'd255, 12'd101, 12'd2000, 1'b1);
    wait_drained();

    // Out-of-range values: upper data bits set, empty window, line shorter than two pixels.
    write_config(13'h1F00, 13'h1F80, 13'h1FFF, 13'h1FFE, 13'd0, 13'd1, 13'd4095, 13'd4095);
    send_word(8'd127, 12'd4095, 12'd1, 1'b0);
    send_word(8'd128, 12'd4094, 12'd1, 1'b1);
    send_word(8'd128, 12'd7, 12'd4, 1'b0);
    send_word(8'd128, 12'd8, 12'd4, 1'b1);
    wait_drained();

    rand_start = words_sent;
    phase      = 0;
    while (words_sent - rand_start < RANDOM_WORDS) begin
      line_no = 12'($urandom_range(0, 4095));
      random_config(line_no);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS && words_sent - rand_start < RANDOM_WORDS)
      begin
        idle_on = (words_sent - rand_start < RANDOM_WORDS - PHASE_WORDS) && (phase % 4 != 2);
        case ($urandom_range(0, 19))
          0, 1: n = 1;
          2: n = int'($urandom_range(20, 64));
          default: n = int'($urandom_range(2, 12));
        endcase
        send_line(n, line_no, $urandom_range(0, 9) == 0);
        line_no = line_no + 12'd1;
        if ($urandom_range(0, 29) == 0) wait_drained();
      end
      wait_drained();
      phase++;
    end

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
